FILE: sv/ctsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the clock time set controller.
// No dependencies; every other file imports this package.
package ctsc_pkg;

    // event kinds on the input word
    localparam logic [2:0] EV_TICK  = 3'd0;
    localparam logic [2:0] EV_MODE  = 3'd1;
    localparam logic [2:0] EV_INC   = 3'd2;
    localparam logic [2:0] EV_DEC   = 3'd3;
    localparam logic [2:0] EV_ENTER = 3'd4;
    localparam logic [2:0] EV_SET   = 3'd5;
    localparam logic [2:0] EV_BLINK = 3'd6;

    // system modes
    localparam logic [1:0] SYS_CLOCK = 2'd0;
    localparam logic [1:0] SYS_TSET  = 2'd1;

    // published event codes
    localparam logic [2:0] OUT_SECOND  = 3'd0;
    localparam logic [2:0] OUT_MINUTE  = 3'd1;
    localparam logic [2:0] OUT_HOUR    = 3'd2;
    localparam logic [2:0] OUT_DISPLAY = 3'd3;
    localparam logic [2:0] OUT_MODE    = 3'd4;
    localparam logic [2:0] OUT_BLINK   = 3'd5;

    // set submodes
    localparam logic [1:0] SUB_NORMAL = 2'd0;
    localparam logic [1:0] SUB_SELECT = 2'd1;
    localparam logic [1:0] SUB_ADJUST = 2'd2;

    // selected units
    localparam logic [1:0] SEL_HOUR   = 2'd0;
    localparam logic [1:0] SEL_MINUTE = 2'd1;
    localparam logic [1:0] SEL_SECOND = 2'd2;

    localparam logic [4:0] HOUR_RESET      = 5'd12;
    localparam logic [5:0] PREV_MIN_RESET  = 6'd60;
    localparam logic [4:0] PREV_HOUR_RESET = 5'd25;
    localparam logic [5:0] HOURS_PER_DAY   = 6'd24;
    localparam logic [6:0] MINS_PER_HOUR   = 7'd60;

    localparam int QUEUE_DEPTH = 2;

    // one published event
    typedef struct packed {
        logic [2:0] code;
        logic [5:0] value;
        logic [1:0] tag;
        logic       wr;
    } res_t;

    // all results of one accepted word plus the register snapshot
    typedef struct packed {
        logic [1:0] count;
        res_t       res2;
        res_t       res1;
        res_t       res0;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [1:0] submode;
        logic [1:0] unit;
    } job_t;

endpackage

FILE: sv/ctsc_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words, holds the clock state, builds result jobs.
// Depends on ctsc_pkg.
module ctsc_front import ctsc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_mode,
    input  logic [1:0] s_system_mode,
    input  logic       s_rtc_ok,
    input  logic [4:0] s_rtc_hour,
    input  logic [5:0] s_rtc_minute,
    input  logic [5:0] s_rtc_second,
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_job
);

    logic [4:0] hour_reg, hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [5:0] second_reg, second_next;
    logic [5:0] prev_minute_reg, prev_minute_next;
    logic [4:0] prev_hour_reg, prev_hour_next;
    logic [1:0] submode_reg, submode_next;
    logic [1:0] unit_reg, unit_next;
    logic       blink_reg, blink_next;

    logic       accept;
    logic       up;
    logic [5:0] h_sum, h_w1, h_w2;
    logic [6:0] m_sum, m_w1, m_w2;
    logic [6:0] s_sum, s_w1, s_w2;
    logic [1:0] cnt;
    res_t       r0, r1, r2;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign up      = (s_mode == EV_INC);

    // wrap arithmetic: two conditional subtracts cover every 5/6-bit input
    always_comb begin
        h_sum = {1'b0, hour_reg} + (up ? 6'd1 : 6'd23);
        h_w1  = (h_sum >= HOURS_PER_DAY) ? h_sum - HOURS_PER_DAY : h_sum;
        h_w2  = (h_w1 >= HOURS_PER_DAY) ? h_w1 - HOURS_PER_DAY : h_w1;
        m_sum = {1'b0, minute_reg} + (up ? 7'd1 : 7'd59);
        m_w1  = (m_sum >= MINS_PER_HOUR) ? m_sum - MINS_PER_HOUR : m_sum;
        m_w2  = (m_w1 >= MINS_PER_HOUR) ? m_w1 - MINS_PER_HOUR : m_w1;
        s_sum = {1'b0, second_reg} + (up ? 7'd1 : 7'd59);
        s_w1  = (s_sum >= MINS_PER_HOUR) ? s_sum - MINS_PER_HOUR : s_sum;
        s_w2  = (s_w1 >= MINS_PER_HOUR) ? s_w1 - MINS_PER_HOUR : s_w1;
    end

    always_comb begin
        hour_next        = hour_reg;
        minute_next      = minute_reg;
        second_next      = second_reg;
        prev_minute_next = prev_minute_reg;
        prev_hour_next   = prev_hour_reg;
        submode_next     = submode_reg;
        unit_next        = unit_reg;
        blink_next       = blink_reg;
        cnt = 2'd0;
        r0  = '0;
        r1  = '0;
        r2  = '0;
        if (s_mode == EV_TICK) begin
            if (s_rtc_ok) begin
                hour_next   = s_rtc_hour;
                minute_next = s_rtc_minute;
                second_next = s_rtc_second;
                r0  = '{code: OUT_SECOND, value: s_rtc_second, tag: s_system_mode, wr: 1'b0};
                cnt = 2'd1;
                if (s_rtc_minute != prev_minute_reg) begin
                    prev_minute_next = s_rtc_minute;
                    r1  = '{code: OUT_MINUTE, value: s_rtc_minute, tag: s_system_mode,
                            wr: 1'b0};
                    cnt = 2'd2;
                    if (s_rtc_hour != prev_hour_reg) begin
                        prev_hour_next = s_rtc_hour;
                        r2  = '{code: OUT_HOUR, value: {1'b0, s_rtc_hour},
                                tag: s_system_mode, wr: 1'b0};
                        cnt = 2'd3;
                    end
                end
            end
        end else if (s_mode == EV_BLINK) begin
            blink_next = !blink_reg;
            r0  = '{code: OUT_BLINK, value: {5'd0, !blink_reg}, tag: SYS_TSET, wr: 1'b0};
            cnt = 2'd1;
        end else if (s_system_mode == SYS_CLOCK) begin
            if (s_mode == EV_MODE) begin
                submode_next = SUB_SELECT;
                unit_next    = SEL_HOUR;
                r0  = '{code: OUT_MODE, value: 6'd1, tag: SYS_CLOCK, wr: 1'b0};
                cnt = 2'd1;
            end
        end else if (s_system_mode == SYS_TSET) begin
            if (submode_reg == SUB_SELECT || submode_reg == SUB_ADJUST) begin
                unique case (s_mode) inside
                    EV_INC, EV_DEC: begin
                        cnt = 2'd1;
                        if (submode_reg == SUB_SELECT) begin
                            if (up) begin
                                unit_next = (unit_reg == SEL_SECOND) ? SEL_HOUR
                                                                     : unit_reg + 2'd1;
                            end else begin
                                unit_next = (unit_reg == SEL_HOUR) ? SEL_SECOND
                                                                   : unit_reg - 2'd1;
                            end
                            r0 = '{code: OUT_DISPLAY, value: 6'd0, tag: SYS_TSET, wr: 1'b0};
                        end else if (unit_reg == SEL_HOUR) begin
                            hour_next = h_w2[4:0];
                            r0 = '{code: OUT_HOUR, value: h_w2, tag: SYS_TSET, wr: 1'b1};
                        end else if (unit_reg == SEL_MINUTE) begin
                            minute_next = m_w2[5:0];
                            r0 = '{code: OUT_MINUTE, value: m_w2[5:0], tag: SYS_TSET,
                                   wr: 1'b1};
                        end else begin
                            second_next = s_w2[5:0];
                            r0 = '{code: OUT_SECOND, value: s_w2[5:0], tag: SYS_TSET,
                                   wr: 1'b1};
                        end
                    end
                    EV_ENTER: begin
                        submode_next = (submode_reg == SUB_SELECT) ? SUB_ADJUST : SUB_SELECT;
                        r0  = '{code: OUT_DISPLAY, value: 6'd0, tag: SYS_TSET, wr: 1'b0};
                        cnt = 2'd1;
                    end
                    EV_SET: begin
                        submode_next = SUB_NORMAL;
                        r0  = '{code: OUT_MODE, value: 6'd0, tag: SYS_TSET, wr: 1'b0};
                        cnt = 2'd1;
                    end
                    default: begin
                        cnt = 2'd0;
                    end
                endcase
            end
        end
    end

    // drop words that publish nothing
    assign q_push = accept && (cnt != 2'd0);
    always_comb begin
        q_job = '{count: cnt, res2: r2, res1: r1, res0: r0, hour: hour_next,
                  minute: minute_next, second: second_next, submode: submode_next,
                  unit: unit_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_reg        <= HOUR_RESET;
            minute_reg      <= '0;
            second_reg      <= '0;
            prev_minute_reg <= PREV_MIN_RESET;
            prev_hour_reg   <= PREV_HOUR_RESET;
            submode_reg     <= SUB_NORMAL;
            unit_reg        <= SEL_HOUR;
            blink_reg       <= 1'b0;
        end else if (accept) begin
            hour_reg        <= hour_next;
            minute_reg      <= minute_next;
            second_reg      <= second_next;
            prev_minute_reg <= prev_minute_next;
            prev_hour_reg   <= prev_hour_next;
            submode_reg     <= submode_next;
            unit_reg        <= unit_next;
            blink_reg       <= blink_next;
        end
    end

endmodule

FILE: sv/ctsc_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front and back ends.
// Depends on ctsc_pkg (job_t, QUEUE_DEPTH).
module ctsc_queue import ctsc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop && !empty) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if ((push && !full) && !(pop && !empty)) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (!(push && !full) && (pop && !empty)) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

FILE: sv/ctsc_back.sv
`timescale 1ns / 1ps
// Back end: takes jobs off the queue and sends their results one word a cycle while m_ready is high.
// Depends on ctsc_pkg.
module ctsc_back import ctsc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  job_t       head_job,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_code,
    output logic [5:0] m_event_value,
    output logic [1:0] m_event_mode,
    output logic       m_rtc_write,
    output logic [4:0] m_cur_hour,
    output logic [5:0] m_cur_minute,
    output logic [5:0] m_cur_second,
    output logic [1:0] m_set_submode,
    output logic [1:0] m_set_unit,
    output logic       m_is_last
);

    job_t       job_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       last;
    logic       done;
    res_t       cur;

    assign last  = (idx_reg == job_reg.count - 2'd1);
    assign done  = valid_reg && m_ready && last;
    assign q_pop = (!valid_reg || done) && !q_empty;

    always_comb begin
        case (idx_reg)
            2'd0:    cur = job_reg.res0;
            2'd1:    cur = job_reg.res1;
            default: cur = job_reg.res2;
        endcase
    end

    assign m_valid       = valid_reg;
    assign m_event_code  = cur.code;
    assign m_event_value = cur.value;
    assign m_event_mode  = cur.tag;
    assign m_rtc_write   = cur.wr;
    assign m_cur_hour    = job_reg.hour;
    assign m_cur_minute  = job_reg.minute;
    assign m_cur_second  = job_reg.second;
    assign m_set_submode = job_reg.submode;
    assign m_set_unit    = job_reg.unit;
    assign m_is_last     = last;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= head_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (done) begin
            valid_reg <= 1'b0;
        end else if (valid_reg && m_ready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

FILE: sv/clock_time_set_controller.sv
`timescale 1ns / 1ps
// Clock time set controller: tick, key and blink words in, published events out.
// A job is written into the job queue, then loaded into the back end's job register.
// Throughput: one input word a cycle while the two-entry job queue has room;
// results leave one a cycle while m_ready is high, so the sustained pace is
// set by the number of results the back end must send for each word.
// Reset (aresetn low, synchronous) restores the clock state and empties the queue.
module clock_time_set_controller import ctsc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_mode,
    input  logic [1:0] s_system_mode,
    input  logic       s_rtc_ok,
    input  logic [4:0] s_rtc_hour,
    input  logic [5:0] s_rtc_minute,
    input  logic [5:0] s_rtc_second,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_code,
    output logic [5:0] m_event_value,
    output logic [1:0] m_event_mode,
    output logic       m_rtc_write,
    output logic [4:0] m_cur_hour,
    output logic [5:0] m_cur_minute,
    output logic [5:0] m_cur_second,
    output logic [1:0] m_set_submode,
    output logic [1:0] m_set_unit,
    output logic       m_is_last
);

    // queue handshake between front and back
    logic q_push, q_pop, q_full, q_empty;
    job_t push_job, head_job;

    // front: decode the word, update the time and set state, build a job
    ctsc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_system_mode (s_system_mode),
        .s_rtc_ok      (s_rtc_ok),
        .s_rtc_hour    (s_rtc_hour),
        .s_rtc_minute  (s_rtc_minute),
        .s_rtc_second  (s_rtc_second),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (push_job)
    );

    // hold jobs so either side can stall on its own
    ctsc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back: send each job's results in order, flag the last one
    ctsc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_job      (head_job),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_code  (m_event_code),
        .m_event_value (m_event_value),
        .m_event_mode  (m_event_mode),
        .m_rtc_write   (m_rtc_write),
        .m_cur_hour    (m_cur_hour),
        .m_cur_minute  (m_cur_minute),
        .m_cur_second  (m_cur_second),
        .m_set_submode (m_set_submode),
        .m_set_unit    (m_set_unit),
        .m_is_last     (m_is_last)
    );

endmodule

FILE: sv/ctsc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the clock time set controller, bound to the top level.
// Depends on ctsc_pkg and clock_time_set_controller.
module ctsc_checker import ctsc_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_event_code,
    input logic [5:0] m_event_value,
    input logic [1:0] m_event_mode,
    input logic       m_rtc_write,
    input logic [1:0] m_set_submode,
    input logic       m_is_last
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_code)
            && $stable(m_event_value) && $stable(m_is_last))
        else $error("stalled result word changed");

    a_write_adjust: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rtc_write |-> m_set_submode == SUB_ADJUST && m_is_last
            && m_event_mode == SYS_TSET)
        else $error("clock write outside value adjustment");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_code == OUT_BLINK || m_event_code == OUT_DISPLAY
            || m_event_code == OUT_MODE) |-> m_is_last)
        else $error("single-result event not marked last");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

endmodule

bind clock_time_set_controller ctsc_checker u_ctsc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_event_code  (m_event_code),
    .m_event_value (m_event_value),
    .m_event_mode  (m_event_mode),
    .m_rtc_write   (m_rtc_write),
    .m_set_submode (m_set_submode),
    .m_is_last     (m_is_last)
);
